FILE: rtl/tick_priority_scheduler_with_semaphores_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tick priority scheduler
// Shared wrappers that clock on i_clk and hold off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TICK_PRIORITY_SCHEDULER_WITH_SEMAPHORES_CORE_DEFINES_SVH
`define TICK_PRIORITY_SCHEDULER_WITH_SEMAPHORES_CORE_DEFINES_SVH

// Same-cycle implication.
`define TPSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TPSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tpss_pkg.sv
// ----------------------------------------------------------------------------
// tpss_pkg
// Sizes, codes, table layout and sequencer states of the scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package tpss_pkg;

    localparam int NUM_PROCS  = 8;
    localparam int NUM_SEMS   = 4;
    localparam int PROC_AW    = $clog2(NUM_PROCS);
    localparam int SEM_AW     = $clog2(NUM_SEMS);
    localparam int Q_DEPTH    = NUM_SEMS * NUM_PROCS;
    localparam int Q_AW       = SEM_AW + PROC_AW;

    localparam int ACTION_W   = 3;
    localparam int PID_W      = 3;
    localparam int SID_W      = 2;
    localparam int MS_W       = 20;
    localparam int PRIO_W     = 8;
    localparam int CNT_W      = 8;
    localparam int TICK_W     = 32;
    localparam int RATE_W     = 10;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic CFG_REG_TICK_RATE = 1'b0;

    localparam int MS_PER_SECOND = 1000;
    localparam logic [MS_W-1:0]   SEM_SLEEP_MS  = MS_W'(100000);
    localparam logic [RATE_W-1:0] TICK_RATE_RST = RATE_W'(100);
    localparam logic signed [CNT_W-1:0] CNT_MIN = -8'sd128;
    localparam logic signed [CNT_W-1:0] CNT_MAX = 8'sd127;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SCHEDULE = 3'd0,
        ACT_CHARGE   = 3'd1,
        ACT_SLEEP    = 3'd2,
        ACT_SEM_P    = 3'd3,
        ACT_SEM_V    = 3'd4,
        ACT_SET_PRIO = 3'd5,
        ACT_SEM_INIT = 3'd6
    } t_action;

    typedef struct packed {
        logic [PRIO_W-1:0] rem;
        logic [PRIO_W-1:0] prio;
        logic [TICK_W-1:0] start;
        logic [MS_W-1:0]   len;
    } t_proc;

    localparam int PROC_W = $bits(t_proc);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEMP,
        S_SEMV,
        S_QHEAD,
        S_P_RD,
        S_P_WR,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_RF_RD,
        S_RF_LD,
        S_RF_MUL,
        S_RF_WR,
        S_Q_RD,
        S_Q_WR,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/tpss_intf.sv
// ----------------------------------------------------------------------------
// tpss_intf
// Valid/ready channels for action beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpss_in_if import tpss_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [ACTION_W-1:0]      action;
    logic [PID_W-1:0]         proc_id;
    logic [SID_W-1:0]         sem_id;
    logic [MS_W-1:0]          sleep_ms;
    logic [PRIO_W-1:0]        priority_value;
    logic signed [CNT_W-1:0]  sem_init_value;
    logic [TICK_W-1:0]        now_tick;

    modport source (output valid, action, proc_id, sem_id, sleep_ms, priority_value,
                    sem_init_value, now_tick, input ready);
    modport sink   (input valid, action, proc_id, sem_id, sleep_ms, priority_value,
                    sem_init_value, now_tick, output ready);
endinterface

interface tpss_out_if import tpss_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     ready_valid;
    logic [PID_W-1:0]         ready_proc;
    logic signed [CNT_W-1:0]  sem_count;

    modport source (output valid, ready_valid, ready_proc, sem_count, input ready);
    modport sink   (input valid, ready_valid, ready_proc, sem_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/tpss_ram.sv
// ----------------------------------------------------------------------------
// tpss_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tpss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/tpss_apb.sv
// ----------------------------------------------------------------------------
// tpss_apb
// APB register slave holding the tick rate.
// ----------------------------------------------------------------------------
`default_nettype none

module tpss_apb import tpss_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [RATE_W-1:0]     o_tick_rate
);

    logic [RATE_W-1:0] r_tick_rate;
    logic [RATE_W-1:0] n_tick_rate;
    logic              hit;

    assign hit = (paddr[CFG_ADDR_W-1] == CFG_REG_TICK_RATE);

    always_comb begin
        n_tick_rate = r_tick_rate;
        if (psel && penable && pwrite && hit) begin
            n_tick_rate = pwdata[RATE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_rate <= TICK_RATE_RST;
        end else begin
            r_tick_rate <= n_tick_rate;
        end
    end

    assign prdata      = hit ? CFG_DATA_W'(r_tick_rate) : '0;
    assign pready      = 1'b1;
    assign o_tick_rate = r_tick_rate;

endmodule

`default_nettype wire

FILE: rtl/tpss_expiry.sv
// ----------------------------------------------------------------------------
// tpss_expiry
// Sleep expiry test: elapsed*1000/rate > len, done as
// elapsed*1000 >= (len+1)*rate with one registered multiply stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tpss_expiry import tpss_pkg::*; (
    input  logic              i_clk,
    input  logic [TICK_W-1:0] i_now,
    input  logic [TICK_W-1:0] i_start,
    input  logic [MS_W-1:0]   i_len,
    input  logic [RATE_W-1:0] i_rate,
    output logic              o_expired
);

    localparam int LHS_W = TICK_W + RATE_W;
    localparam int RHS_W = MS_W + 1 + RATE_W;

    logic [TICK_W-1:0] elapsed;
    logic [RATE_W-1:0] rate_eff;
    logic [LHS_W-1:0]  r_lhs;
    logic [RHS_W-1:0]  r_rhs;

    assign elapsed  = i_now - i_start;
    // a zero rate counts as one
    assign rate_eff = (i_rate == '0) ? RATE_W'(1) : i_rate;

    always_ff @(posedge i_clk) begin
        r_lhs <= LHS_W'(elapsed) * LHS_W'(MS_PER_SECOND);
        r_rhs <= (RHS_W'(i_len) + RHS_W'(1)) * RHS_W'(rate_eff);
    end

    assign o_expired = (r_lhs >= LHS_W'(r_rhs));

endmodule

`default_nettype wire

FILE: rtl/tpss_seq.sv
// ----------------------------------------------------------------------------
// tpss_seq
// Action sequencer around the process table and semaphore queue RAMs.
// ----------------------------------------------------------------------------
`default_nettype none

module tpss_seq import tpss_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [RATE_W-1:0] i_tick_rate,
    tpss_in_if.sink           i_in,
    tpss_out_if.source        o_out
);

    localparam logic [PROC_AW-1:0] IDX_LAST = PROC_AW'(NUM_PROCS - 1);

    t_state r_state, n_state;

    logic [ACTION_W-1:0]     r_act, n_act;
    logic [PID_W-1:0]        r_pid, n_pid;
    logic [SID_W-1:0]        r_sid, n_sid;
    logic [MS_W-1:0]         r_ms, n_ms;
    logic [PRIO_W-1:0]       r_prio, n_prio;
    logic [TICK_W-1:0]       r_now, n_now;

    logic [PROC_AW-1:0]      r_idx, n_idx;
    logic                    r_pass, n_pass;
    logic [PRIO_W-1:0]       r_best, n_best;
    logic [PROC_AW-1:0]      r_best_idx, n_best_idx;
    logic [PID_W-1:0]        r_cur_ready, n_cur_ready;
    logic                    r_cur_valid, n_cur_valid;
    logic signed [CNT_W-1:0] r_sem [NUM_SEMS];
    logic signed [CNT_W-1:0] n_sem [NUM_SEMS];
    logic [NUM_PROCS-1:0]    r_pvalid, n_pvalid;
    logic                    r_rd_ok;
    t_proc                   r_ent, n_ent;
    logic [PROC_AW-1:0]      r_qi, n_qi;
    logic [PROC_AW-1:0]      r_qn, n_qn;

    logic                    r_o_valid, n_o_valid;
    logic                    r_o_rv, n_o_rv;
    logic [PID_W-1:0]        r_o_rp, n_o_rp;
    logic signed [CNT_W-1:0] r_o_sc, n_o_sc;

    logic                    p_we;
    logic [PROC_AW-1:0]      p_waddr, p_raddr;
    t_proc                   p_wdata;
    logic [PROC_W-1:0]       p_rdata;
    t_proc                   p_rdata_m;
    logic                    q_we;
    logic [Q_AW-1:0]         q_waddr, q_raddr;
    logic [PID_W-1:0]        q_wdata, q_rdata;
    logic                    expired;
    logic                    in_ready;

    tpss_ram #(.WIDTH(PROC_W), .DEPTH(NUM_PROCS)) u_proc_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    tpss_ram #(.WIDTH(PID_W), .DEPTH(Q_DEPTH)) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    tpss_expiry u_expiry (
        .i_clk     (i_clk),
        .i_now     (r_now),
        .i_start   (r_ent.start),
        .i_len     (r_ent.len),
        .i_rate    (i_tick_rate),
        .o_expired (expired)
    );

    // never-written table entries read as zero
    assign p_rdata_m = r_rd_ok ? t_proc'(p_rdata) : '0;

    always_comb begin
        t_proc                   ent;
        logic [SEM_AW-1:0]       sidx;
        logic signed [CNT_W-1:0] cur;
        logic signed [CNT_W-1:0] dec;
        logic signed [CNT_W-1:0] inc;
        logic [CNT_W-1:0]        slot;
        logic [CNT_W:0]          negc;
        logic [PRIO_W-1:0]       bv;
        logic [PROC_AW-1:0]      bi;
        logic                    pok;
        logic                    sok;
        logic                    o_free;

        n_state     = r_state;
        n_act       = r_act;
        n_pid       = r_pid;
        n_sid       = r_sid;
        n_ms        = r_ms;
        n_prio      = r_prio;
        n_now       = r_now;
        n_idx       = r_idx;
        n_pass      = r_pass;
        n_best      = r_best;
        n_best_idx  = r_best_idx;
        n_cur_ready = r_cur_ready;
        n_cur_valid = r_cur_valid;
        n_sem       = r_sem;
        n_pvalid    = r_pvalid;
        n_ent       = r_ent;
        n_qi        = r_qi;
        n_qn        = r_qn;
        n_o_rv      = r_o_rv;
        n_o_rp      = r_o_rp;
        n_o_sc      = r_o_sc;

        o_free    = !r_o_valid || o_out.ready;
        n_o_valid = r_o_valid && !o_out.ready;

        p_we    = 1'b0;
        p_waddr = PROC_AW'(r_pid);
        p_wdata = '0;
        p_raddr = r_idx;
        q_we    = 1'b0;
        q_waddr = '0;
        q_wdata = r_pid;
        q_raddr = '0;
        in_ready = 1'b0;

        sidx = SEM_AW'(r_sid);
        cur  = r_sem[sidx];
        dec  = (cur == CNT_MIN) ? cur : cur - 8'sd1;
        inc  = (cur == CNT_MAX) ? cur : cur + 8'sd1;
        slot = ~dec;
        negc = (CNT_W + 1)'(0) - {inc[CNT_W-1], inc};
        ent  = p_rdata_m;
        bv   = r_best;
        bi   = r_best_idx;
        pok  = (32'(i_in.proc_id) < NUM_PROCS);
        sok  = (32'(i_in.sem_id) < NUM_SEMS);

        case (r_state)
            S_IDLE: begin
                in_ready = 1'b1;
                if (i_in.valid) begin
                    n_act  = i_in.action;
                    n_pid  = i_in.proc_id;
                    n_sid  = i_in.sem_id;
                    n_ms   = i_in.sleep_ms;
                    n_prio = i_in.priority_value;
                    n_now  = i_in.now_tick;
                    n_state = S_DONE;
                    case (i_in.action)
                        ACT_SCHEDULE: begin
                            n_idx   = '0;
                            n_pass  = 1'b0;
                            n_best  = '0;
                            n_state = S_SCAN_RD;
                        end
                        ACT_CHARGE, ACT_SLEEP, ACT_SET_PRIO: begin
                            if (pok) begin
                                n_state = S_P_RD;
                            end
                        end
                        ACT_SEM_P: begin
                            if (pok && sok) begin
                                n_state = S_SEMP;
                            end
                        end
                        ACT_SEM_V: begin
                            if (sok) begin
                                n_state = S_SEMV;
                            end
                        end
                        ACT_SEM_INIT: begin
                            if (sok) begin
                                n_sem[SEM_AW'(i_in.sem_id)] = i_in.sem_init_value;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_SEMP: begin
                n_sem[sidx] = dec;
                n_state     = S_DONE;
                if (dec < 0) begin
                    // enqueue at slot -count-1 when it fits
                    if (32'(slot) < NUM_PROCS) begin
                        q_we    = 1'b1;
                        q_waddr = {sidx, slot[PROC_AW-1:0]};
                    end
                    n_ms    = SEM_SLEEP_MS;
                    n_state = S_P_RD;
                end
            end

            S_SEMV: begin
                n_sem[sidx] = inc;
                n_state     = S_DONE;
                if (inc <= 0) begin
                    q_raddr = {sidx, PROC_AW'(0)};
                    n_qi    = '0;
                    n_qn    = (negc >= (CNT_W + 1)'(NUM_PROCS - 1)) ? IDX_LAST
                                                                   : negc[PROC_AW-1:0];
                    n_state = S_QHEAD;
                end
            end

            S_QHEAD: begin
                n_pid       = q_rdata;
                n_cur_ready = q_rdata;
                n_cur_valid = 1'b1;
                n_state     = S_P_RD;
            end

            S_P_RD: begin
                p_raddr = PROC_AW'(r_pid);
                n_state = S_P_WR;
            end

            S_P_WR: begin
                n_state = S_DONE;
                case (r_act)
                    ACT_CHARGE: begin
                        if (ent.rem != '0) begin
                            ent.rem = ent.rem - PRIO_W'(1);
                        end
                    end
                    ACT_SLEEP, ACT_SEM_P: begin
                        ent.rem   = '0;
                        ent.start = r_now;
                        ent.len   = r_ms;
                        n_idx     = '0;
                        n_pass    = 1'b0;
                        n_best    = '0;
                        n_state   = S_SCAN_RD;
                    end
                    ACT_SET_PRIO: begin
                        ent.prio = r_prio;
                        ent.rem  = r_prio;
                    end
                    ACT_SEM_V: begin
                        ent.len = '0;
                        ent.rem = ent.prio;
                        if (r_qn != '0) begin
                            n_state = S_Q_RD;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
                p_we    = 1'b1;
                p_wdata = ent;
                n_pvalid[PROC_AW'(r_pid)] = 1'b1;
            end

            S_SCAN_RD: begin
                n_state = S_SCAN_CHK;
            end

            S_SCAN_CHK: begin
                // strict compare keeps the lowest index on ties
                if (ent.rem > r_best) begin
                    bv = ent.rem;
                    bi = r_idx;
                end
                n_best     = bv;
                n_best_idx = bi;
                if (r_idx == IDX_LAST) begin
                    if (bv != '0) begin
                        n_cur_ready = PID_W'(bi);
                        n_cur_valid = 1'b1;
                        n_state     = S_DONE;
                    end else if (!r_pass) begin
                        n_idx   = '0;
                        n_state = S_RF_RD;
                    end else begin
                        n_cur_ready = '0;
                        n_cur_valid = 1'b0;
                        n_state     = S_DONE;
                    end
                end else begin
                    n_idx   = r_idx + PROC_AW'(1);
                    n_state = S_SCAN_RD;
                end
            end

            S_RF_RD: begin
                n_state = S_RF_LD;
            end

            S_RF_LD: begin
                n_ent   = p_rdata_m;
                n_state = S_RF_MUL;
            end

            S_RF_MUL: begin
                n_state = S_RF_WR;
            end

            S_RF_WR: begin
                ent = r_ent;
                if (r_ent.len != '0) begin
                    if (expired) begin
                        ent.len = '0;
                        ent.rem = r_ent.prio;
                    end
                end else begin
                    ent.rem = r_ent.prio;
                end
                p_we    = 1'b1;
                p_waddr = r_idx;
                p_wdata = ent;
                n_pvalid[r_idx] = 1'b1;
                if (r_idx == IDX_LAST) begin
                    n_idx   = '0;
                    n_pass  = 1'b1;
                    n_best  = '0;
                    n_state = S_SCAN_RD;
                end else begin
                    n_idx   = r_idx + PROC_AW'(1);
                    n_state = S_RF_RD;
                end
            end

            S_Q_RD: begin
                q_raddr = {sidx, r_qi + PROC_AW'(1)};
                n_state = S_Q_WR;
            end

            S_Q_WR: begin
                q_we    = 1'b1;
                q_waddr = {sidx, r_qi};
                q_wdata = q_rdata;
                n_qi    = r_qi + PROC_AW'(1);
                n_state = ((r_qi + PROC_AW'(1)) == r_qn) ? S_DONE : S_Q_RD;
            end

            S_DONE: begin
                if (o_free) begin
                    n_o_valid = 1'b1;
                    n_o_rv    = r_cur_valid;
                    n_o_rp    = r_cur_valid ? r_cur_ready : '0;
                    n_o_sc    = (32'(r_sid) < NUM_SEMS) ? cur : '0;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur_ready <= '0;
            r_cur_valid <= 1'b0;
            r_pvalid    <= '0;
            r_o_valid   <= 1'b0;
            r_pass      <= 1'b0;
            for (int i = 0; i < NUM_SEMS; i++) begin
                r_sem[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_cur_ready <= n_cur_ready;
            r_cur_valid <= n_cur_valid;
            r_pvalid    <= n_pvalid;
            r_o_valid   <= n_o_valid;
            r_pass      <= n_pass;
            r_sem       <= n_sem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_pid      <= n_pid;
        r_sid      <= n_sid;
        r_ms       <= n_ms;
        r_prio     <= n_prio;
        r_now      <= n_now;
        r_idx      <= n_idx;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_ent      <= n_ent;
        r_qi       <= n_qi;
        r_qn       <= n_qn;
        r_o_rv     <= n_o_rv;
        r_o_rp     <= n_o_rp;
        r_o_sc     <= n_o_sc;
        r_rd_ok    <= r_pvalid[p_raddr];
    end

    assign i_in.ready        = in_ready;
    assign o_out.valid       = r_o_valid;
    assign o_out.ready_valid = r_o_rv;
    assign o_out.ready_proc  = r_o_rp;
    assign o_out.sem_count   = r_o_sc;

endmodule

`default_nettype wire

FILE: rtl/tick_priority_scheduler_with_semaphores_core.sv
// ----------------------------------------------------------------------------
// tick_priority_scheduler_with_semaphores_core
// Priority/tick process scheduler with counting semaphores and FIFO waiters.
// Each input beat carries one action and the current tick count and yields
// exactly one result beat: the selected process (with a valid flag) and the
// count of the addressed semaphore. The process table (ticks, priority, sleep
// start and length) sits in an 8-entry RAM, the wait queues in a 32-entry
// RAM; one sequencer reads, modifies and writes them back. Semaphore init
// and ignored actions go straight to the result; semaphore P that does not
// block and V that wakes nobody update the count only; charge and set
// priority read and write back one table entry. A schedule scans the table
// entry by entry; when all ticks are zero it refills each entry (read, load,
// multiply, write) and scans again. Sleep and a blocking semaphore P write
// the caller's sleep into its entry before the schedule. A waking V reads the
// queue head, updates that process's entry and shifts up to 7 queue slots.
// A new beat is taken once the previous result sits in the output register,
// even if that result has not yet been taken; a result that is held back
// stalls the next beat at its final step. The tick rate is an APB register
// at byte 0 (reset 100; zero acts as one).
// ----------------------------------------------------------------------------
`default_nettype none
`include "tick_priority_scheduler_with_semaphores_core_defines.svh"

module tick_priority_scheduler_with_semaphores_core import tpss_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tpss_in_if.sink               i_in,
    tpss_out_if.source            o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [RATE_W-1:0] tick_rate;

    // configuration registers
    tpss_apb u_apb (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_tick_rate (tick_rate)
    );

    // sequencer with process table and wait queue memories
    tpss_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick_rate (tick_rate),
        .i_in        (i_in),
        .o_out       (o_out)
    );

    // a taken beat makes the block busy in the next cycle
    `TPSS_ASSERT_NEXT(a_busy_after_accept, i_in.valid && i_in.ready, !i_in.ready, "accepted while busy")
    // no process number is shown when none is selected
    `TPSS_ASSERT_NOW(a_idle_proc_zero, o_out.valid && !o_out.ready_valid, o_out.ready_proc == '0, "proc without valid")
    // a new result follows a busy cycle
    `TPSS_ASSERT_NOW(a_result_after_work, $rose(o_out.valid), $past(!i_in.ready), "result without work")

endmodule

`default_nettype wire
